[design/sh256_pkg.sv]
// Shared types, constants and functions for the SHA-256 stream hasher.
// Used by the controller, the message schedule, the round unit and the top level.
// No dependencies.
package sh256_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_OUT
    } state_t;

    // Control bundle from the sequencer to the datapath modules.
    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       round_load;
        logic       round_step;
        logic [5:0] round_idx;
        logic       chain_update;
        logic       chain_init;
        logic [2:0] out_idx;
    } ctl_t;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] ROUND_END = 6'd63;
    localparam logic [2:0] WORD_END  = 3'd7;

    // Initial hash values.
    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants.
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[design/sh256_ctrl.sv]
// Sequencer for the SHA-256 stream hasher: byte intake, padding, rounds and digest output.
// Depends on sh256_pkg.
module sh256_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        msg_byte,
    input  logic              no_byte,
    input  logic              msg_end,
    output logic              out_valid,
    input  logic              out_ready,
    output sh256_pkg::ctl_t   ctl
);
    import sh256_pkg::*;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bit_total_reg, bit_total_next;
    logic [5:0]  round_cnt_reg, round_cnt_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        pad_active_reg, pad_active_next;
    logic        pad_first_reg, pad_first_next;
    logic        len_mode_reg, len_mode_next;

    logic        in_acc;
    logic        out_acc;
    logic        push_msg;
    logic        pad_push;
    logic        len_byte;
    logic [7:0]  pad_byte;

    // Handshake decode.
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;
    assign push_msg  = in_acc && !no_byte;
    assign pad_push  = (state_reg == ST_PAD);

    // Padding byte: the marker first, then zeros, then the length from position 56 on.
    assign len_byte = pad_push && !pad_first_reg && (len_mode_reg || (fill_reg == LEN_POS));
    always_comb
    begin
        priority if (pad_first_reg)
        begin
            pad_byte = PAD_MARK;
        end
        else if (len_byte)
        begin
            pad_byte = bit_total_reg[63:56];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (push_msg && (fill_reg == FILL_LAST))
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (msg_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                if (round_cnt_reg == ROUND_END)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (len_mode_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (pad_active_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == FILL_LAST)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_OUT:
            begin
                if (out_acc && (out_idx_reg == WORD_END))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs to the datapath.
    always_comb
    begin
        ctl.push         = push_msg || pad_push;
        ctl.push_byte    = pad_push ? pad_byte : msg_byte;
        ctl.round_load   = (push_msg || pad_push) && (fill_reg == FILL_LAST);
        ctl.round_step   = (state_reg == ST_ROUND);
        ctl.round_idx    = round_cnt_reg;
        ctl.chain_update = (state_reg == ST_UPDATE);
        ctl.chain_init   = out_acc && (out_idx_reg == WORD_END);
        ctl.out_idx      = out_idx_reg;
    end

    // Counters and flags.
    always_comb
    begin
        fill_next       = fill_reg;
        bit_total_next  = bit_total_reg;
        pad_active_next = pad_active_reg;
        pad_first_next  = pad_first_reg;
        len_mode_next   = len_mode_reg;
        out_idx_next    = out_idx_reg;
        round_cnt_next  = ctl.round_step ? round_cnt_reg + 6'd1 : 6'd0;

        if (ctl.push)
        begin
            fill_next = fill_reg + 6'd1;
        end
        if (push_msg)
        begin
            bit_total_next = bit_total_reg + 64'd8;
        end
        else if (len_byte)
        begin
            bit_total_next = {bit_total_reg[55:0], 8'h00};
        end
        if (in_acc && msg_end)
        begin
            pad_active_next = 1'b1;
            pad_first_next  = 1'b1;
        end
        if (pad_push)
        begin
            pad_first_next = 1'b0;
        end
        if (len_byte)
        begin
            len_mode_next = 1'b1;
        end
        if (out_acc)
        begin
            out_idx_next = out_idx_reg + 3'd1;
        end
        if (ctl.chain_init)
        begin
            fill_next       = 6'd0;
            bit_total_next  = 64'd0;
            pad_active_next = 1'b0;
            pad_first_next  = 1'b0;
            len_mode_next   = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= 6'd0;
            bit_total_reg  <= 64'd0;
            round_cnt_reg  <= 6'd0;
            out_idx_reg    <= 3'd0;
            pad_active_reg <= 1'b0;
            pad_first_reg  <= 1'b0;
            len_mode_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            bit_total_reg  <= bit_total_next;
            round_cnt_reg  <= round_cnt_next;
            out_idx_reg    <= out_idx_next;
            pad_active_reg <= pad_active_next;
            pad_first_reg  <= pad_first_next;
            len_mode_reg   <= len_mode_next;
        end
    end

    // The last round always hands over to the chaining update.
    a_round_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && (round_cnt_reg == ROUND_END) |=> (state_reg == ST_UPDATE))
        else $error("round sequence did not end in the chaining update");

    // The length block's update leads straight to the digest output.
    a_len_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) && len_mode_reg |=> (state_reg == ST_OUT))
        else $error("final block did not lead to digest output");

    // The length bytes fill the block exactly, so the block is empty during output.
    a_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (fill_reg == 6'd0))
        else $error("byte count not zero while the digest is sent");

    // Length bytes are only sent while a message is being closed.
    a_len_in_pad: assert property (@(posedge clk) disable iff (!rst_n)
        len_mode_reg |-> pad_active_reg)
        else $error("length phase outside padding");

endmodule

[design/sh256_sched.sv]
// Message window for SHA-256: loads the block a byte at a time and expands the schedule.
// Depends on sh256_pkg.
module sh256_sched (
    input  logic              clk,
    input  sh256_pkg::ctl_t   ctl,
    output logic [31:0]       w_cur
);
    import sh256_pkg::*;

    logic [31:0] window_reg  [16];
    logic [31:0] window_next [16];
    logic [31:0] w_new;

    // Next schedule word from the taps at t+14, t+9, t+1 and t.
    assign w_new = small_sigma1(window_reg[14]) + window_reg[9]
                 + small_sigma0(window_reg[1]) + window_reg[0];

    assign w_cur = window_reg[0];

    // Byte load shifts the whole block left by eight bits; a round shifts by one word.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            window_next[i] = window_reg[i];
        end
        if (ctl.push)
        begin
            for (int i = 0; i < 15; i++)
            begin
                window_next[i] = {window_reg[i][23:0], window_reg[i + 1][31:24]};
            end
            window_next[15] = {window_reg[15][23:0], ctl.push_byte};
        end
        else if (ctl.round_step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                window_next[i] = window_reg[i + 1];
            end
            window_next[15] = w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

endmodule

[design/sh256_round.sv]
// SHA-256 round unit and chaining words; one round per cycle, reused for all 64 rounds.
// Depends on sh256_pkg.
module sh256_round (
    input  logic              clk,
    input  logic              rst_n,
    input  sh256_pkg::ctl_t   ctl,
    input  logic [31:0]       w_cur,
    output logic [31:0]       digest_word
);
    import sh256_pkg::*;

    logic [31:0] work_reg  [8];
    logic [31:0] work_next [8];
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] t1;
    logic [31:0] t2;

    // One compression round.
    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + ROUND_K[ctl.round_idx] + w_cur;
    assign t2 = big_sigma0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));

    // Working variables: loaded from the chain at block start, then rotated each round.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            work_next[i] = work_reg[i];
        end
        if (ctl.round_load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_next[i] = chain_reg[i];
            end
        end
        else if (ctl.round_step)
        begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end
    end

    // Chaining words: add the block result, or restart after a digest.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            chain_next[i] = chain_reg[i];
            if (ctl.chain_init)
            begin
                chain_next[i] = INIT_H[i];
            end
            else if (ctl.chain_update)
            begin
                chain_next[i] = chain_reg[i] + work_reg[i];
            end
        end
    end

    assign digest_word = chain_reg[ctl.out_idx];

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_H[i];
            end
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

endmodule

[design/sha256_stream_hasher.sv]
// SHA-256 over a byte stream. Each accepted beat without no_byte takes one message byte;
// every 64th byte starts a compression that runs 64 rounds through a single round unit,
// one round per cycle, and then folds the result into the chaining words. A beat with
// msg_end set closes the message: padding is loaded one byte per cycle (up to 64 bytes,
// or up to 72 when the padding spills into a second block), each padding block is then
// compressed in the same way, and the digest leaves as eight output beats, word 0 first.
// in_ready is low while a block is compressed, and from the closing beat until the last
// digest word is taken.
// Depends on sh256_pkg, sh256_ctrl, sh256_sched and sh256_round.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  msg_byte,
    input  logic        no_byte,
    input  logic        msg_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);
    import sh256_pkg::*;

    ctl_t        ctl;
    logic [31:0] w_cur;

    sh256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .msg_byte  (msg_byte),
        .no_byte   (no_byte),
        .msg_end   (msg_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    sh256_sched u_sched (
        .clk   (clk),
        .ctl   (ctl),
        .w_cur (w_cur)
    );

    sh256_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .w_cur       (w_cur),
        .digest_word (digest_word)
    );

    // Word position and end-of-digest mark.
    assign word_index  = ctl.out_idx;
    assign digest_last = (ctl.out_idx == WORD_END);

endmodule
